// ===== src/ucrr_pkg.sv =====
// ----------------------------------------------------------------------------
// ucrr_pkg
// Shared constants, types and the descriptor table of the control responder.
// ----------------------------------------------------------------------------
package ucrr_pkg;

  localparam int MAX_PACKET_BYTES = 8;
  localparam int ROM_DEPTH        = 128;
  localparam int ROM_USED         = 110;

  localparam logic [1:0] OP_SETUP = 2'd0;
  localparam logic [1:0] OP_TX    = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
  localparam logic [7:0] REQ_GET_DESC    = 8'd6;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'd9;

  localparam logic [7:0] DESC_TYPE_DEVICE = 8'd1;
  localparam logic [7:0] DESC_TYPE_CONFIG = 8'd2;
  localparam logic [7:0] DESC_TYPE_STRING = 8'd3;

  localparam logic [7:0] PID_DATA1 = 8'h4B;
  localparam logic [7:0] PID_DATA0 = 8'hC3;

  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_OUT
  } state_t;

  function automatic logic [7:0] rom_byte(input logic [7:0] a);
    logic [7:0] r;
    r = 8'd0;
    case (a)
      8'd0: r = 8'd18;   8'd1: r = 8'd1;    8'd2: r = 8'h10;   8'd3: r = 8'h01;
      8'd7: r = 8'd8;    8'd8: r = 8'hC0;   8'd9: r = 8'h16;   8'd10: r = 8'hDF;
      8'd11: r = 8'h05;  8'd13: r = 8'h01;  8'd14: r = 8'd1;   8'd15: r = 8'd2;
      8'd16: r = 8'd3;   8'd17: r = 8'd1;
      8'd18: r = 8'd9;   8'd19: r = 8'd2;   8'd20: r = 8'd34;  8'd22: r = 8'd1;
      8'd23: r = 8'd1;   8'd25: r = 8'h80;  8'd26: r = 8'd50;
      8'd27: r = 8'd9;   8'd28: r = 8'd4;   8'd31: r = 8'd1;   8'd32: r = 8'd3;
      8'd36: r = 8'd9;   8'd37: r = 8'h21;  8'd38: r = 8'h01;  8'd39: r = 8'h01;
      8'd41: r = 8'h01;  8'd42: r = 8'h22;
      8'd45: r = 8'd7;   8'd46: r = 8'd5;   8'd47: r = 8'h81;  8'd48: r = 8'h03;
      8'd49: r = 8'd8;   8'd51: r = 8'd100;
      8'd52: r = 8'd4;   8'd53: r = 8'd3;   8'd54: r = 8'h09;  8'd55: r = 8'h04;
      8'd56: r = 8'd22;  8'd57: r = 8'd3;   8'd58: r = "C";    8'd60: r = "O";
      8'd62: r = "K";    8'd64: r = "P";    8'd66: r = "O";    8'd68: r = "W";
      8'd70: r = "E";    8'd72: r = "H";    8'd74: r = "E";    8'd76: r = "U";
      8'd78: r = 8'd24;  8'd79: r = 8'd3;   8'd80: r = "H";    8'd82: r = "I";
      8'd84: r = "D";    8'd86: r = " ";    8'd88: r = "e";    8'd90: r = "x";
      8'd92: r = "a";    8'd94: r = "m";    8'd96: r = "p";    8'd98: r = "l";
      8'd100: r = "e";
      8'd102: r = 8'd8;  8'd103: r = 8'd3;  8'd104: r = "0";   8'd106: r = ".";
      8'd108: r = "1";
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/ucrr_crc.sv =====
// ----------------------------------------------------------------------------
// ucrr_crc
// Bit-serial USB CRC-16, one data bit per cycle while shift is high, least significant bit first.
// ----------------------------------------------------------------------------
module ucrr_crc (
  input  logic        clk,
  input  logic        init,
  input  logic        shift,
  input  logic        din,
  output logic [15:0] crc
);

  logic [15:0] crc_next;

  always_comb begin
    crc_next = crc;
    if (init) begin
      crc_next = 16'hFFFF;
    end else if (shift) begin
      crc_next = {1'b0, crc[15:1]} ^ ((crc[0] ^ din) ? ucrr_pkg::CRC_POLY : 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    crc <= crc_next;
  end

endmodule

// ===== src/usb_control_request_responder.sv =====
// A setup, bus reset or idle transmit item passes from idle to the output
// state; a transmit item with reply bytes first passes the send state, where
// the bit-serial CRC shifts one data bit per cycle.
// One item is in work at a time; the next is taken once the result is taken.
// Synchronous reset clears the state, reply bookkeeping, address and configuration.
// ----------------------------------------------------------------------------
// usb_control_request_responder
// Endpoint-zero setup decoder and descriptor reply packetizer.
// ----------------------------------------------------------------------------
module usb_control_request_responder #(
  parameter int MAX_PACKET_BYTES = ucrr_pkg::MAX_PACKET_BYTES,
  parameter int ROM_DEPTH        = ucrr_pkg::ROM_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [3:0]  packet_len,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [7:0]  value_low,
  input  logic [7:0]  value_high,
  input  logic [7:0]  length_low,
  input  logic [7:0]  length_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tx_valid,
  output logic [7:0]  tx_pid,
  output logic [63:0] tx_data,
  output logic [3:0]  tx_count,
  output logic [15:0] tx_crc,
  output logic        reply_done,
  output logic [7:0]  pending_address,
  output logic [7:0]  configuration_value
);

  ucrr_pkg::state_t state, state_next;

  logic       reply_pending;
  logic [7:0] bytes_remaining;
  logic [6:0] rom_position;
  logic       data_toggle;
  logic [7:0] cur_byte;
  logic [2:0] bit_cnt;
  logic [3:0] byte_cnt;
  logic [3:0] n_bytes;
  logic       crc_init;
  logic       crc_shift;
  logic [15:0] crc;
  logic [7:0] rom_q;
  logic       accept;
  logic [7:0] len_sel;
  logic [6:0] at_sel;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ucrr_pkg::ST_IDLE) && !out_valid;

  always_comb begin
    rom_q = (32'(rom_position) < ROM_DEPTH) ? ucrr_pkg::rom_byte({1'b0, rom_position})
                                           : 8'd0;
  end

  always_comb begin
    len_sel = 8'd0;
    at_sel  = rom_position;
    if (request_type[6:5] == 2'd0 && request_code == ucrr_pkg::REQ_GET_DESC) begin
      unique case (value_high)
        ucrr_pkg::DESC_TYPE_DEVICE: begin at_sel = 7'd0;  len_sel = 8'd18; end
        ucrr_pkg::DESC_TYPE_CONFIG: begin at_sel = 7'd18; len_sel = 8'd34; end
        ucrr_pkg::DESC_TYPE_STRING: begin
          case (value_low)
            8'd0: begin at_sel = 7'd52;  len_sel = 8'd4;  end
            8'd1: begin at_sel = 7'd56;  len_sel = 8'd22; end
            8'd2: begin at_sel = 7'd78;  len_sel = 8'd24; end
            8'd3: begin at_sel = 7'd102; len_sel = 8'd8;  end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    if (length_high == 8'd0 && len_sel > length_low) len_sel = length_low;
  end

  assign crc_init  = accept;
  assign crc_shift = (state == ucrr_pkg::ST_SEND) && (byte_cnt != n_bytes);

  ucrr_crc u_crc (
    .clk   (clk),
    .init  (crc_init),
    .shift (crc_shift),
    .din   (cur_byte[0]),
    .crc   (crc)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ucrr_pkg::ST_IDLE: if (accept) begin
        state_next = (opcode == ucrr_pkg::OP_TX && reply_pending) ?
                     ucrr_pkg::ST_SEND : ucrr_pkg::ST_OUT;
      end
      ucrr_pkg::ST_SEND: if (byte_cnt == n_bytes) state_next = ucrr_pkg::ST_OUT;
      ucrr_pkg::ST_OUT:  state_next = ucrr_pkg::ST_IDLE;
      default: state_next = ucrr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ucrr_pkg::ST_IDLE;
      out_valid <= 1'b0;
      reply_pending <= 1'b0;
      bytes_remaining <= 8'd0;
      rom_position <= 7'd0;
      data_toggle <= 1'b0;
      pending_address <= 8'd0;
      configuration_value <= 8'd0;
      tx_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (accept) begin
        tx_valid <= 1'b0;
        tx_pid <= 8'd0;
        tx_data <= 64'd0;
        tx_count <= 4'd0;
        tx_crc <= 16'd0;
        reply_done <= 1'b0;
        byte_cnt <= 4'd0;
        bit_cnt <= 3'd0;
        unique case (opcode)
          ucrr_pkg::OP_SETUP: if (packet_len == 4'd8) begin
            if (request_type[6:5] == 2'd0 && request_code == ucrr_pkg::REQ_SET_ADDRESS)
              pending_address <= value_low;
            if (request_type[6:5] == 2'd0 && request_code == ucrr_pkg::REQ_SET_CONFIG)
              configuration_value <= value_low;
            rom_position <= at_sel;
            bytes_remaining <= len_sel;
            data_toggle <= 1'b0;
            reply_pending <= 1'b1;
          end
          ucrr_pkg::OP_TX: if (reply_pending) begin
            n_bytes <= (bytes_remaining > 8'(MAX_PACKET_BYTES)) ?
                       4'(MAX_PACKET_BYTES) : bytes_remaining[3:0];
            cur_byte <= rom_q;
          end
          ucrr_pkg::OP_RESET: pending_address <= 8'd0;
          default: ;
        endcase
      end
      if (state == ucrr_pkg::ST_SEND) begin
        if (byte_cnt != n_bytes) begin
          tx_data <= {cur_byte[0], tx_data[63:1]};
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            byte_cnt <= byte_cnt + 4'd1;
            rom_position <= rom_position + 7'd1;
            cur_byte <= ucrr_pkg::rom_byte({1'b0, rom_position + 7'd1}) &
                        {8{32'(7'(rom_position + 7'd1)) < ROM_DEPTH}};
          end else begin
            cur_byte <= {1'b0, cur_byte[7:1]};
          end
        end else begin
          if (bit_cnt == 3'd0 && byte_cnt != 4'd8) begin
            tx_data <= tx_data >> (7'd64 - {byte_cnt, 3'd0});
          end
          tx_valid <= 1'b1;
          tx_pid <= data_toggle ? ucrr_pkg::PID_DATA0 : ucrr_pkg::PID_DATA1;
          data_toggle <= ~data_toggle;
          tx_count <= n_bytes;
          tx_crc <= ~crc;
          bytes_remaining <= bytes_remaining - {4'd0, n_bytes};
          if (n_bytes < 4'(MAX_PACKET_BYTES)) begin
            reply_done <= 1'b1;
            reply_pending <= 1'b0;
          end
        end
      end
      if (state == ucrr_pkg::ST_OUT) out_valid <= 1'b1;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result held");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tx_count <= 4'(MAX_PACKET_BYTES)) else $error("count too large");
  a_done_short: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reply_done) |-> tx_valid && tx_count < 4'(MAX_PACKET_BYTES))
    else $error("done on full packet");
  a_pid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tx_valid) |-> (tx_pid == ucrr_pkg::PID_DATA0 ||
    tx_pid == ucrr_pkg::PID_DATA1)) else $error("bad pid");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives setup, transmit, bus-reset and unknown-opcode items into the control
// responder with bursty input and a stalling output, predicts each reply
// packet and checks every result field against the prediction.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_pid;
    logic [63:0] tx_data;
    logic [3:0]  tx_count;
    logic [15:0] tx_crc;
    logic        reply_done;
    logic [7:0]  pending_address;
    logic [7:0]  configuration_value;
  } packet_t;

  class packet_scoreboard;
    packet_t pending_packets[$];
    int errors;
    bit     m_pending;
    logic [7:0] m_left;
    logic [6:0] m_pos;
    logic   m_toggle;
    logic [7:0] m_addr;
    logic [7:0] m_cfg;
    logic [7:0] desc_rom[128];

    function new();
      errors = 0;
      m_pending = 0; m_left = 0; m_pos = 0; m_toggle = 0; m_addr = 0; m_cfg = 0;
      desc_rom = '{
        18, 1, 8'h10, 8'h01, 0, 0, 0, 8, 8'hC0, 8'h16, 8'hDF, 8'h05, 8'h00, 8'h01,
        1, 2, 3, 1,
        9, 2, 34, 0, 1, 1, 0, 8'h80, 50,
        9, 4, 0, 0, 1, 3, 0, 0, 0,
        9, 8'h21, 8'h01, 8'h01, 8'h00, 8'h01, 8'h22, 0, 0,
        7, 5, 8'h81, 8'h03, 8, 0, 100,
        4, 3, 8'h09, 8'h04,
        22, 3, "C", 0, "O", 0, "K", 0, "P", 0, "O", 0, "W", 0, "E", 0, "H", 0,
        "E", 0, "U", 0,
        24, 3, "H", 0, "I", 0, "D", 0, " ", 0, "e", 0, "x", 0, "a", 0, "m", 0,
        "p", 0, "l", 0, "e", 0,
        8, 3, "0", 0, ".", 0, "1", 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    endfunction

    function void note_item(logic [1:0] op, logic [3:0] plen, logic [7:0] rtype,
                            logic [7:0] code, logic [7:0] vlo, logic [7:0] vhi,
                            logic [7:0] llo, logic [7:0] lhi);
      packet_t p;
      logic [7:0] len, n, b;
      logic [6:0] at;
      logic [15:0] crc;
      p = '0;
      if (op == ucrr_pkg::OP_SETUP && plen == 4'd8) begin
        len = 0;
        at = m_pos;
        if (rtype[6:5] == 2'd0) begin
          if (code == ucrr_pkg::REQ_SET_ADDRESS) m_addr = vlo;
          else if (code == ucrr_pkg::REQ_SET_CONFIG) m_cfg = vlo;
          else if (code == ucrr_pkg::REQ_GET_DESC) begin
            if (vhi == ucrr_pkg::DESC_TYPE_DEVICE) begin
              at = 0; len = 18;
            end else if (vhi == ucrr_pkg::DESC_TYPE_CONFIG) begin
              at = 18; len = 34;
            end else if (vhi == ucrr_pkg::DESC_TYPE_STRING) begin
              case (vlo)
                8'd0: begin at = 52; len = 4; end
                8'd1: begin at = 56; len = 22; end
                8'd2: begin at = 78; len = 24; end
                8'd3: begin at = 102; len = 8; end
                default: ;
              endcase
            end
          end
        end
        if (lhi == 0 && len > llo) len = llo;
        m_pos = at; m_left = len; m_toggle = 0; m_pending = 1;
      end else if (op == ucrr_pkg::OP_TX && m_pending) begin
        n = (m_left > 8) ? 8'd8 : m_left;
        m_left = m_left - n;
        p.tx_pid = m_toggle ? ucrr_pkg::PID_DATA0 : ucrr_pkg::PID_DATA1;
        m_toggle = ~m_toggle;
        crc = 16'hFFFF;
        for (int i = 0; i < n; i++) begin
          b = desc_rom[m_pos];
          m_pos = m_pos + 7'd1;
          p.tx_data[8*i +: 8] = b;
          crc = crc ^ {8'd0, b};
          for (int k = 0; k < 8; k++) crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
        end
        p.tx_crc = ~crc;
        p.tx_count = n[3:0];
        p.tx_valid = 1;
        if (n < 8) begin
          p.reply_done = 1;
          m_pending = 0;
        end
      end else if (op == ucrr_pkg::OP_RESET) begin
        m_addr = 0;
      end
      p.pending_address = m_addr;
      p.configuration_value = m_cfg;
      pending_packets.push_back(p);
    endfunction

    function void check_packet(packet_t got);
      packet_t want;
      if (pending_packets.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_packets.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic [1:0] opcode = 0;
  logic [3:0] packet_len = 0;
  logic [7:0] request_type = 0, request_code = 0, value_low = 0, value_high = 0;
  logic [7:0] length_low = 0, length_high = 0;
  logic in_ready, out_valid, tx_valid, reply_done;
  logic [7:0] tx_pid, pending_address, configuration_value;
  logic [63:0] tx_data;
  logic [3:0] tx_count;
  logic [15:0] tx_crc;
  packet_scoreboard sb = new();
  int stall_mode = 0;

  usb_control_request_responder DUT (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_packet({tx_valid, tx_pid, tx_data, tx_count, tx_crc, reply_done,
                       pending_address, configuration_value});
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk) if (($urandom & 255) == 0) stall_mode <= $urandom_range(0, 2);

  int burst_left = 0;

  task automatic send_item(logic [1:0] op, logic [3:0] plen, logic [7:0] rt,
                           logic [7:0] rc, logic [7:0] vl, logic [7:0] vh,
                           logic [7:0] ll, logic [7:0] lh);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1; opcode <= op; packet_len <= plen; request_type <= rt;
    request_code <= rc; value_low <= vl; value_high <= vh;
    length_low <= ll; length_high <= lh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, plen, rt, rc, vl, vh, ll, lh);
    if (burst_left == 0) in_valid <= 0;
  endtask

  task automatic drain();
    if (burst_left != 0) begin
      in_valid <= 0;
      burst_left = 0;
    end
    while (sb.pending_packets.size() != 0) @(posedge clk);
  endtask

  task automatic send_setup(logic [7:0] rt, logic [7:0] rc, logic [7:0] vl,
                            logic [7:0] vh, logic [7:0] ll, logic [7:0] lh);
    send_item(ucrr_pkg::OP_SETUP, 4'd8, rt, rc, vl, vh, ll, lh);
  endtask

  task automatic send_tx();
    send_item(ucrr_pkg::OP_TX, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    logic [7:0] rt, rc, vl, vh, ll, lh;
    int r;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_tx();
    send_setup(8'h80, ucrr_pkg::REQ_GET_DESC, 8'd0, ucrr_pkg::DESC_TYPE_DEVICE, 8'hFF, 8'd0);
    repeat (4) send_tx();
    send_setup(8'h00, ucrr_pkg::REQ_SET_ADDRESS, 8'hFF, 8'd0, 8'd0, 8'd0);
    send_tx();
    send_item(ucrr_pkg::OP_RESET, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_setup(8'h00, ucrr_pkg::REQ_SET_CONFIG, 8'hFF, 8'd0, 8'd0, 8'hFF);
    send_setup(8'hFF, ucrr_pkg::REQ_GET_DESC, 8'd0, ucrr_pkg::DESC_TYPE_DEVICE, 8'hFF, 8'd0);
    send_tx();
    send_setup(8'h80, ucrr_pkg::REQ_GET_DESC, 8'd3, ucrr_pkg::DESC_TYPE_STRING, 8'd8, 8'd0);
    send_tx(); send_tx(); send_tx();
    send_item(ucrr_pkg::OP_SETUP, 4'd7, 8'd0, ucrr_pkg::REQ_SET_ADDRESS, 8'h55, 8'd0,
              8'd0, 8'd0);
    send_item(2'd3, 4'hF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_setup(8'h80, ucrr_pkg::REQ_GET_DESC, 8'd9, ucrr_pkg::DESC_TYPE_STRING, 8'hFF, 8'hFF);
    send_tx();
    send_setup(8'h80, ucrr_pkg::REQ_GET_DESC, 8'd0, ucrr_pkg::DESC_TYPE_CONFIG, 8'd5, 8'd0);
    send_tx();
    drain();
    for (int i = 0; i < 500; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        rt = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
             {1'($urandom_range(0, 1)), 2'b00, 5'($urandom)};
        case ($urandom_range(0, 4))
          0: rc = ucrr_pkg::REQ_SET_ADDRESS;
          1: rc = ucrr_pkg::REQ_SET_CONFIG;
          2, 3: rc = ucrr_pkg::REQ_GET_DESC;
          default: rc = 8'($urandom);
        endcase
        vh = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3));
        vl = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        lh = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd0;
        ll = 8'($urandom);
        send_setup(rt, rc, vl, vh, ll, lh);
      end else if (r < 88) begin
        send_tx();
      end else if (r < 93) begin
        send_item(ucrr_pkg::OP_RESET, 4'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_item(2'($urandom), 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom));
      end
      if (i == 250) drain();
    end
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/ucrr_pkg.sv
src/ucrr_crc.sv
src/usb_control_request_responder.sv
tb/tb_top.sv
